### rtl/utl_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to Latin transcoder package
// Shared types, the Latin-9 code tables and the code point mapping function.
// ----------------------------------------------------------------------------
package utl_pkg;

  typedef enum logic [1:0] {
    ENC_PASS   = 2'd0,
    ENC_LATIN1 = 2'd1,
    ENC_LATIN9 = 2'd2,
    ENC_UNUSED = 2'd3
  } enc_e;

  localparam int unsigned L9_ENTRIES = 8;

  localparam logic [7:0] L9_BYTE [L9_ENTRIES] = '{
    8'hA4, 8'hA6, 8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE
  };

  localparam logic [15:0] L9_CP [L9_ENTRIES] = '{
    16'h20AC, 16'h0160, 16'h0161, 16'h017D,
    16'h017E, 16'h0152, 16'h0153, 16'h0178
  };

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       word_end;
    logic       word_ok;
  } res_t;

  typedef struct packed {
    logic pend_zero;
    logic failed;
  } front_status_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] byte_val;
  } map_t;

  function automatic map_t map_cp(logic [15:0] cp, logic is_l9);
    map_t       res;
    logic       hit;
    logic       replaced;
    logic [7:0] hit_byte;
    res      = '0;
    hit      = 1'b0;
    replaced = 1'b0;
    hit_byte = '0;
    for (int k = 0; k < L9_ENTRIES; k++) begin
      if (is_l9 && (cp == L9_CP[k])) begin
        hit      = 1'b1;
        hit_byte = L9_BYTE[k];
      end
      if (is_l9 && (cp[15:8] == 8'h00) && (cp[7:0] == L9_BYTE[k])) begin
        replaced = 1'b1;
      end
    end
    if (hit) begin
      res.ok       = 1'b1;
      res.byte_val = hit_byte;
    end else if (replaced || (cp[15:8] != 8'h00)) begin
      res.ok       = 1'b0;
      res.byte_val = '0;
    end else begin
      res.ok       = 1'b1;
      res.byte_val = cp[7:0];
    end
    return res;
  endfunction

endpackage

### rtl/utl_front.sv
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts input bytes, decodes UTF-8 sequences, maps code points and keeps
// the per-word decode state; results are pushed into the queue.
// ----------------------------------------------------------------------------
module utl_front import utl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  enc_e          enc_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_word_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output res_t          push_data_o,
  output front_status_t status_o
);

  logic [1:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;
  logic        failed_q, failed_d;

  logic        accept;
  logic        have;
  logic [7:0]  ob;
  logic        done;
  logic [15:0] cp;
  map_t        mapped;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    failed_d = failed_q;
    have     = 1'b0;
    ob       = '0;
    done     = 1'b0;
    cp       = '0;
    mapped   = '0;
    case (enc_i)
      ENC_PASS: begin
        have = 1'b1;
        ob   = in_byte_i;
      end
      ENC_UNUSED: begin
        failed_d = 1'b1;
      end
      default: begin
        if (!failed_q) begin
          if (pend_q == 2'd0) begin
            if (in_byte_i inside {[8'h00:8'h7F]}) begin
              cp   = {8'h00, in_byte_i};
              done = 1'b1;
            end else if (in_byte_i[7:5] == 3'b110) begin
              part_d = {5'd0, in_byte_i[4:0], 6'd0};
              pend_d = 2'd1;
            end else if (in_byte_i[7:4] == 4'b1110) begin
              part_d = {in_byte_i[3:0], 12'd0};
              pend_d = 2'd2;
            end else begin
              failed_d = 1'b1;
            end
          end else if (pend_q == 2'd2) begin
            part_d = part_q | {4'd0, in_byte_i[5:0], 6'd0};
            pend_d = 2'd1;
          end else begin
            cp     = part_q | {10'd0, in_byte_i[5:0]};
            pend_d = 2'd0;
            part_d = '0;
            done   = 1'b1;
          end
          if (done) begin
            mapped = map_cp(cp, enc_i == ENC_LATIN9);
            if (mapped.ok) begin
              have = 1'b1;
              ob   = mapped.byte_val;
            end else begin
              failed_d = 1'b1;
            end
          end
          if (end_of_word_i && (pend_d != 2'd0)) begin
            failed_d = 1'b1;
          end
        end
      end
    endcase
  end

  assign push_o               = accept && (have || end_of_word_i);
  assign push_data_o.has_byte = have;
  assign push_data_o.out_byte = have ? ob : 8'h00;
  assign push_data_o.word_end = end_of_word_i;
  assign push_data_o.word_ok  = end_of_word_i && !failed_d;

  assign status_o.pend_zero = (pend_q == 2'd0);
  assign status_o.failed    = failed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      part_q   <= '0;
      failed_q <= 1'b0;
    end else if (accept) begin
      if (end_of_word_i) begin
        pend_q   <= '0;
        part_q   <= '0;
        failed_q <= 1'b0;
      end else begin
        pend_q   <= pend_d;
        part_q   <= part_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

### rtl/utl_fifo.sv
// ----------------------------------------------------------------------------
// Transcoder result queue
// Two-entry queue that decouples the decoder from the output stage.
// ----------------------------------------------------------------------------
module utl_fifo import utl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t pop_data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/utl_back.sv
// ----------------------------------------------------------------------------
// Transcoder output stage
// Moves results from the queue into the output register and holds each one
// until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module utl_back import utl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  res_t       pop_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       word_end_o,
  output logic       word_ok_o
);

  logic valid_q, valid_d;
  res_t data_q;

  assign pop_o   = !empty_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= pop_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign has_byte_o  = data_q.has_byte;
  assign out_byte_o  = data_q.out_byte;
  assign word_end_o  = data_q.word_end;
  assign word_ok_o   = data_q.word_ok;

endmodule

### rtl/utf8_to_latin_transcoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 to Latin transcoder
// Converts the UTF-8 bytes of a word into pass-through, Latin-1 or Latin-9.
// ----------------------------------------------------------------------------
// The input channel takes one UTF-8 byte per transfer, with end_of_word_i
// marking the last byte of a word. The output channel gives at most one
// result per input byte: a converted byte when a character completes, and
// a word-end result carrying word_ok_o on the last byte of every word.
// The user must write the target set through cfg_we_i and cfg_wdata_i only
// while idle; the block does not enforce it. One byte is taken every cycle
// while in_ready_o is high, as the decoder resolves each byte, including
// the eight-entry Latin-9 compare, combinationally. A two-entry queue and
// the output register sit between the decoder and the output port. When
// the receiver stalls, the queue fills and in_ready_o drops once it holds
// two results. Reset clears the decode state, the queue and the output
// register and selects pass-through.
// ----------------------------------------------------------------------------
module utf8_to_latin_transcoder_top import utl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] out_byte_o,
  output logic       word_end_o,
  output logic       word_ok_o
);

  enc_e          enc_q;
  logic          push;
  res_t          push_data;
  logic          full;
  logic          pop;
  logic          empty;
  res_t          pop_data;
  front_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_PASS;
    end else if (cfg_we_i) begin
      enc_q <= enc_e'(cfg_wdata_i);
    end
  end

  utl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enc_i         (enc_q),
    .in_valid_i    (in_valid_i),
    .in_byte_i     (in_byte_i),
    .end_of_word_i (end_of_word_i),
    .in_ready_o    (in_ready_o),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data),
    .status_o      (status)
  );

  utl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  utl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .has_byte_o  (has_byte_o),
    .out_byte_o  (out_byte_o),
    .word_end_o  (word_end_o),
    .word_ok_o   (word_ok_o)
  );

`ifndef SYNTHESIS
  a_word_clears_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_word_i) |=> (status.pend_zero && !status.failed)
  ) else $error("Decode state not cleared after the last byte of a word.");

  a_pass_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (enc_q == ENC_PASS)) |=> (!empty || out_valid_o)
  ) else $error("Pass-through transfer produced no result.");

  a_ok_only_at_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.word_ok) |-> end_of_word_i
  ) else $error("Word status reported before the end of a word.");

  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    full |-> (!push && !in_ready_o)
  ) else $error("Result pushed into a full queue.");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to Latin transcoder testbench
// Directed word tests for each target set and each rejection cause, then
// random words over changing target sets. Every accepted input byte runs
// through a local decoder model, and each output transfer is checked
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import utl_pkg::*;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       word_end;
    logic       word_ok;
  } xlat_result_t;

  localparam logic [15:0] EURO_CP [8] = '{
    16'h20AC, 16'h0160, 16'h0161, 16'h017D,
    16'h017E, 16'h0152, 16'h0153, 16'h0178
  };
  localparam logic [7:0] EURO_BYTE [8] = '{
    8'hA4, 8'hA6, 8'hA8, 8'hB4, 8'hB8, 8'hBC, 8'hBD, 8'hBE
  };
  localparam int IDLE_PCT    = 28;
  localparam int SETTLE_CYC  = 8;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_wdata_i   = ENC_PASS;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_word_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       has_byte_o;
  logic [7:0] out_byte_o;
  logic       word_end_o;
  logic       word_ok_o;

  enc_e         cur_enc;
  logic [1:0]   dec_pending;
  logic [15:0]  dec_partial;
  logic         dec_failed;
  xlat_result_t xlat_result_q [$];
  int           err_cnt;
  logic         idle_on;

  utf8_to_latin_transcoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_word_i (end_of_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .has_byte_o    (has_byte_o),
    .out_byte_o    (out_byte_o),
    .word_end_o    (word_end_o),
    .word_ok_o     (word_ok_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic to_latin(input logic [15:0] cp, input enc_e enc,
                                    output logic [7:0] lb);
    int k;
    lb = 8'h00;
    if (enc == ENC_LATIN9) begin
      for (k = 0; k < 8; k++) begin
        if (cp == EURO_CP[k]) begin
          lb = EURO_BYTE[k];
          return 1'b1;
        end
      end
      for (k = 0; k < 8; k++) begin
        if (cp == {8'h00, EURO_BYTE[k]}) return 1'b0;
      end
    end
    if (cp > 16'h00FF) return 1'b0;
    lb = cp[7:0];
    return 1'b1;
  endfunction

  function automatic logic predict_transcode(input logic [7:0] b, input logic eow,
                                             output xlat_result_t r);
    logic        have;
    logic        done;
    logic [7:0]  ob;
    logic [15:0] cp;
    have = 1'b0;
    done = 1'b0;
    ob   = 8'h00;
    cp   = 16'h0000;
    if (cur_enc == ENC_PASS) begin
      have = 1'b1;
      ob   = b;
    end else if (cur_enc == ENC_UNUSED) begin
      dec_failed = 1'b1;
    end else if (!dec_failed) begin
      if (dec_pending == 2'd0) begin
        if (b[7] == 1'b0) begin
          cp   = {8'h00, b};
          done = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          dec_partial = {5'd0, b[4:0], 6'd0};
          dec_pending = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          dec_partial = {b[3:0], 12'd0};
          dec_pending = 2'd2;
        end else begin
          dec_failed = 1'b1;
        end
      end else if (dec_pending == 2'd2) begin
        dec_partial = dec_partial | {4'd0, b[5:0], 6'd0};
        dec_pending = 2'd1;
      end else begin
        cp          = dec_partial | {10'd0, b[5:0]};
        dec_pending = 2'd0;
        dec_partial = 16'h0000;
        done        = 1'b1;
      end
      if (done) begin
        if (to_latin(cp, cur_enc, ob)) begin
          have = 1'b1;
        end else begin
          dec_failed = 1'b1;
          ob         = 8'h00;
        end
      end
      if (eow && (dec_pending != 2'd0)) dec_failed = 1'b1;
    end
    r.has_byte = have;
    r.out_byte = have ? ob : 8'h00;
    r.word_end = eow;
    r.word_ok  = eow && !dec_failed;
    if (eow) begin
      dec_pending = 2'd0;
      dec_partial = 16'h0000;
      dec_failed  = 1'b0;
    end
    return have || eow;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Output side: random back-pressure and the check of every transfer.
  always @(posedge clk_i) begin
    xlat_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (xlat_result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h end %b",
                                  out_byte_o, word_end_o));
      end else begin
        want = xlat_result_q.pop_front();
        if (has_byte_o !== want.has_byte)
          report_mismatch($sformatf("has_byte %b, want %b", has_byte_o, want.has_byte));
        if (out_byte_o !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_byte_o, want.out_byte));
        if (word_end_o !== want.word_end)
          report_mismatch($sformatf("word_end %b, want %b", word_end_o, want.word_end));
        if (word_ok_o !== want.word_ok)
          report_mismatch($sformatf("word_ok %b, want %b", word_ok_o, want.word_ok));
      end
    end
    out_ready_i <= (idle_on && ($urandom_range(99) < IDLE_PCT)) ? 1'b0 : 1'b1;
  end

  task automatic send_byte(input logic [7:0] b, input logic eow);
    int           idle;
    xlat_result_t r;
    idle = 0;
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) idle++;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_word_i <= eow;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_transcode(b, eow, r)) xlat_result_q = {xlat_result_q, r};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (xlat_result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_encoding(input enc_e enc);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enc;
    @(posedge clk_i);
    cur_enc = enc;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(input logic [7:0] bytes [$]);
    int i;
    for (i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic push_utf8(inout logic [7:0] bytes [$], input logic [15:0] cp);
    if (cp < 16'h0080) begin
      bytes = {bytes, cp[7:0]};
    end else if (cp < 16'h0800) begin
      bytes = {bytes, {3'b110, cp[10:6]}};
      bytes = {bytes, {2'b10, cp[5:0]}};
    end else begin
      bytes = {bytes, {4'b1110, cp[15:12]}};
      bytes = {bytes, {2'b10, cp[11:6]}};
      bytes = {bytes, {2'b10, cp[5:0]}};
    end
  endtask

  // Mostly well-formed words, with raw, noisy and cut-short sequences mixed in.
  task automatic send_random_word(output int n_bytes);
    logic [7:0] bytes [$];
    int         n_chars;
    int         c;
    int         pick;
    logic       cut;
    cut     = 1'b0;
    n_chars = $urandom_range(5, 1);
    for (c = 0; c < n_chars && !cut; c++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_utf8(bytes, 16'($urandom_range(16'h007F)));
      end else if (pick < 55) begin
        push_utf8(bytes, 16'($urandom_range(16'h00FF, 16'h0080)));
      end else if (pick < 70) begin
        push_utf8(bytes, EURO_CP[$urandom_range(7)]);
      end else if (pick < 80) begin
        bytes = {bytes, 8'($urandom_range(8'hDF, 8'hC0))};
        bytes = {bytes, 8'($urandom_range(255))};
      end else if (pick < 88) begin
        bytes = {bytes, 8'($urandom_range(8'hEF, 8'hE0))};
        bytes = {bytes, 8'($urandom_range(255))};
        bytes = {bytes, 8'($urandom_range(255))};
      end else if (pick < 95) begin
        bytes = {bytes, 8'($urandom_range(255))};
      end else begin
        bytes = {bytes, 8'($urandom_range(8'hEF, 8'hC0))};
        if ($urandom_range(1)) bytes = {bytes, 8'($urandom_range(8'hBF, 8'h80))};
        cut = 1'b1;
      end
    end
    n_bytes = bytes.size();
    send_word(bytes);
  endtask

  task automatic test_reset_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_latin1();
    set_encoding(ENC_LATIN1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA4, 1'b1);
    // A code point above 0xFF fails the word and mutes the rest.
    send_byte(8'hC4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_latin9();
    set_encoding(ENC_LATIN9);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hC5, 1'b0);
    send_byte(8'hB8, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA4, 1'b1);
  endtask

  task automatic test_bad_sequences();
    send_byte(8'h80, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hA0, 1'b1);
  endtask

  task automatic test_unused_encoding();
    set_encoding(ENC_UNUSED);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_midword_switch();
    set_encoding(ENC_LATIN1);
    send_byte(8'hC3, 1'b0);
    set_encoding(ENC_LATIN9);
    send_byte(8'hA9, 1'b1);
  endtask

  task automatic test_random_words();
    enc_e phase_enc [8];
    int   phase_len [8];
    int   p;
    int   sent;
    int   n;
    logic paused;
    phase_enc = '{ENC_LATIN9, ENC_LATIN1, ENC_PASS, ENC_LATIN9,
                  ENC_UNUSED, ENC_LATIN1, ENC_LATIN9, ENC_PASS};
    phase_len = '{130, 130, 100, 150, 30, 130, 140, 90};
    for (p = 0; p < 8; p++) begin
      set_encoding(phase_enc[p]);
      idle_on = (p != 5);
      sent    = 0;
      paused  = 1'b0;
      while (sent < phase_len[p]) begin
        send_random_word(n);
        sent += n;
        if (p == 3 && !paused && sent > phase_len[p] / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    cur_enc     = ENC_PASS;
    dec_pending = 2'd0;
    dec_partial = 16'h0000;
    dec_failed  = 1'b0;
    err_cnt     = 0;
    idle_on     = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_passthrough();
    test_latin1();
    test_latin9();
    test_bad_sequences();
    test_unused_encoding();
    test_midword_switch();
    test_random_words();
    wait_drained();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### utf8_to_latin_transcoder_top.f
rtl/utl_pkg.sv
rtl/utl_front.sv
rtl/utl_fifo.sv
rtl/utl_back.sv
rtl/utf8_to_latin_transcoder_top.sv
bench/tb_top.sv
